// File: hw/rtl/bam_aux_pkg.sv
// Shared types, codes and helpers for the BAM auxiliary-field parser.
// Used by bam_aux_tag_parser and bam_aux_result_checker; depends on nothing else.
package bam_aux_pkg;

  // Result kinds (carried on out_tuser)
  typedef enum logic [1:0] {
    KIND_SCALAR = 2'd0,
    KIND_CHAR   = 2'd1,
    KIND_END    = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_t;

  // Type codes
  localparam logic [3:0] CODE_A    = 4'd0;
  localparam logic [3:0] CODE_C8   = 4'd1;
  localparam logic [3:0] CODE_U8   = 4'd2;
  localparam logic [3:0] CODE_S16  = 4'd3;
  localparam logic [3:0] CODE_U16  = 4'd4;
  localparam logic [3:0] CODE_S32  = 4'd5;
  localparam logic [3:0] CODE_U32  = 4'd6;
  localparam logic [3:0] CODE_F32  = 4'd7;
  localparam logic [3:0] CODE_Z    = 4'd8;
  localparam logic [3:0] CODE_NONE = 4'd15;

  // One result word
  typedef struct packed {
    kind_t       kind;
    logic [15:0] tag_chars;
    logic [3:0]  type_code;
    logic [31:0] value;
    logic [7:0]  string_char;
  } result_t;

  // Type byte to type code; CODE_NONE for H, B and unknown bytes
  function automatic logic [3:0] type_of(input logic [7:0] b);
    logic [3:0] code;
    unique case (b)
      8'h41:   code = CODE_A;    // 'A'
      8'h63:   code = CODE_C8;   // 'c'
      8'h43:   code = CODE_U8;   // 'C'
      8'h73:   code = CODE_S16;  // 's'
      8'h53:   code = CODE_U16;  // 'S'
      8'h69:   code = CODE_S32;  // 'i'
      8'h49:   code = CODE_U32;  // 'I'
      8'h66:   code = CODE_F32;  // 'f'
      8'h5A:   code = CODE_Z;    // 'Z'
      default: code = CODE_NONE;
    endcase
    return code;
  endfunction

  // Index of the last value byte of a scalar type
  function automatic logic [1:0] last_index(input logic [3:0] code);
    logic [1:0] idx;
    if (code <= CODE_U8) begin
      idx = 2'd0;
    end else if (code <= CODE_U16) begin
      idx = 2'd1;
    end else begin
      idx = 2'd3;
    end
    return idx;
  endfunction

endpackage

// File: hw/rtl/bam_aux_tag_parser.sv
// BAM auxiliary-field parser: bytes in, one word per scalar, char, string end or error.
// Depends on bam_aux_pkg.
//
// Takes one byte of a record's auxiliary block per cycle while in_tready is high
// (in_tlast marks the last byte of the record) and returns at most one result
// per byte. Each byte updates the parse state in the cycle it is accepted, and
// its result goes to a two-entry output register (output stage plus skid stage),
// so the block sustains one byte per cycle while the output side keeps up; after
// the output side stalls it keeps taking bytes until a second result is waiting,
// and in_tready depends only on the skid register. A result is registered in the
// output stage, or in the skid stage while the output stage stalls, and out_tvalid
// shows the output stage. Scalars (A c C s S i I f) come out as one word when
// their last byte arrives, Z strings as one word per character plus an end word;
// H, B, unknown types and records that end inside a field give an error word,
// after which the rest of the record (for bad types) is skipped.
module bam_aux_tag_parser (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // end_of_record
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [15:0] tag_chars, [19:16] type_code,
                                  // [51:20] value, [59:52] string_char, [63:60] zero
  output logic [1:0]  out_tuser   // [1:0] kind
);

  typedef enum logic [2:0] {
    PH_TAG0 = 3'd0,
    PH_TAG1 = 3'd1,
    PH_TYPE = 3'd2,
    PH_VAL  = 3'd3,
    PH_STR  = 3'd4,
    PH_SKIP = 3'd5
  } phase_t;

  phase_t      phase_r,    phase_nxt;
  logic [15:0] name_r,     name_nxt;
  logic [3:0]  type_r,     type_nxt;
  logic [1:0]  bcount_r,   bcount_nxt;
  logic [31:0] acc_r,      acc_nxt;

  bam_aux_pkg::result_t out_r, skid_r, res;
  logic                 out_valid_r, skid_valid_r;
  logic                 res_valid;
  logic                 in_fire;
  logic [3:0]           code;
  logic [31:0]          acc_ins;

  assign in_tready = !skid_valid_r;
  assign in_fire   = in_tvalid && in_tready;

  assign code    = bam_aux_pkg::type_of(in_tdata);
  // scalar byte merged into the accumulator at its little-endian slot
  assign acc_ins = acc_r | ({24'd0, in_tdata} << {bcount_r, 3'b000});

  // parse step for one byte
  always_comb begin
    phase_nxt  = phase_r;
    name_nxt   = name_r;
    type_nxt   = type_r;
    bcount_nxt = bcount_r;
    acc_nxt    = acc_r;
    res_valid  = 1'b0;
    res        = '0;
    unique case (phase_r)
      PH_TAG1: begin
        name_nxt = {in_tdata, name_r[7:0]};
        if (in_tlast) begin
          phase_nxt = PH_TAG0;
          res_valid = 1'b1;
          res.kind  = bam_aux_pkg::KIND_ERROR;
        end else begin
          phase_nxt = PH_TYPE;
        end
      end
      PH_TYPE: begin
        if (code == bam_aux_pkg::CODE_NONE) begin
          type_nxt  = bam_aux_pkg::CODE_A;
          phase_nxt = in_tlast ? PH_TAG0 : PH_SKIP;
          res_valid = 1'b1;
          res.kind  = bam_aux_pkg::KIND_ERROR;
        end else begin
          type_nxt   = code;
          bcount_nxt = 2'd0;
          acc_nxt    = '0;
          if (in_tlast) begin
            phase_nxt     = PH_TAG0;
            res_valid     = 1'b1;
            res.kind      = bam_aux_pkg::KIND_ERROR;
            res.type_code = code;
          end else begin
            phase_nxt = (code == bam_aux_pkg::CODE_Z) ? PH_STR : PH_VAL;
          end
        end
      end
      PH_VAL: begin
        acc_nxt = acc_ins;
        if (bcount_r >= bam_aux_pkg::last_index(type_r)) begin
          phase_nxt     = PH_TAG0;
          res_valid     = 1'b1;
          res.kind      = bam_aux_pkg::KIND_SCALAR;
          res.type_code = type_r;
          res.value     = acc_ins;
        end else if (in_tlast) begin
          phase_nxt     = PH_TAG0;
          res_valid     = 1'b1;
          res.kind      = bam_aux_pkg::KIND_ERROR;
          res.type_code = type_r;
        end else begin
          bcount_nxt = bcount_r + 2'd1;
        end
      end
      PH_STR: begin
        res_valid     = 1'b1;
        res.type_code = bam_aux_pkg::CODE_Z;
        if (in_tdata == 8'd0) begin
          phase_nxt = PH_TAG0;
          res.kind  = bam_aux_pkg::KIND_END;
        end else if (in_tlast) begin
          phase_nxt = PH_TAG0;
          res.kind  = bam_aux_pkg::KIND_ERROR;
        end else begin
          res.kind        = bam_aux_pkg::KIND_CHAR;
          res.string_char = in_tdata;
        end
      end
      PH_SKIP: begin
        if (in_tlast) begin
          phase_nxt = PH_TAG0;
        end
      end
      default: begin
        // first tag byte; unused phase codes behave the same
        name_nxt = {8'd0, in_tdata};
        type_nxt = bam_aux_pkg::CODE_A;
        if (in_tlast) begin
          phase_nxt = PH_TAG0;
          res_valid = 1'b1;
          res.kind  = bam_aux_pkg::KIND_ERROR;
        end else begin
          phase_nxt = PH_TAG1;
        end
      end
    endcase
    res.tag_chars = name_nxt;
  end

  // parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_TAG0;
      name_r   <= '0;
      type_r   <= '0;
      bcount_r <= '0;
      acc_r    <= '0;
    end else if (in_fire) begin
      phase_r  <= phase_nxt;
      name_r   <= name_nxt;
      type_r   <= type_nxt;
      bcount_r <= bcount_nxt;
      acc_r    <= acc_nxt;
    end
  end

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= in_fire && res_valid;
      end
    end else if (in_fire && res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else if (in_fire && res_valid) begin
        out_r <= res;
      end
    end else if (in_fire && res_valid) begin
      skid_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.kind;
  assign out_tdata  = {4'd0, out_r.string_char, out_r.value, out_r.type_code, out_r.tag_chars};

  // a word in the skid stage always has one ahead of it
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid stage holds a word while output stage is empty");

  // string characters always carry the Z type code
  a_char_is_z: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.kind == bam_aux_pkg::KIND_CHAR |->
      out_r.type_code == bam_aux_pkg::CODE_Z)
    else $error("string char result without Z type code");

  // bytes skipped after a bad type never produce a result
  a_skip_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && phase_r == PH_SKIP |-> !res_valid)
    else $error("result produced while skipping a record");

  // nothing is presented right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r && !skid_valid_r)
    else $error("output valid after reset");

endmodule

// File: tb/sv/bam_aux_result_checker.sv
// Result checker for the BAM auxiliary-field parser: watches both streams,
// predicts each result word from the accepted bytes and compares them.
// Depends on bam_aux_pkg.
module bam_aux_result_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // end_of_record
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [63:0] out_tdata,  // [15:0] tag_chars, [19:16] type_code,
                                  // [51:20] value, [59:52] string_char, [63:60] zero
  input  logic [1:0]  out_tuser,  // [1:0] kind
  output int          fail_count,
  output int          results_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    WAIT_TAG0 = 3'd0,
    WAIT_TAG1 = 3'd1,
    WAIT_TYPE = 3'd2,
    IN_VALUE  = 3'd3,
    IN_STRING = 3'd4,
    SKIPPING  = 3'd5
  } parse_phase_t;

  // Parser state as predicted from the accepted bytes
  parse_phase_t phase_q;
  logic [15:0]  tag_q;
  logic [3:0]   type_q;
  logic [1:0]   idx_q;
  logic [31:0]  acc_q;

  bam_aux_pkg::result_t expected_results[$];

  function automatic logic [3:0] decode_type(input logic [7:0] b);
    unique case (b)
      8'h41:   return bam_aux_pkg::CODE_A;    // A
      8'h63:   return bam_aux_pkg::CODE_C8;   // c
      8'h43:   return bam_aux_pkg::CODE_U8;   // C
      8'h73:   return bam_aux_pkg::CODE_S16;  // s
      8'h53:   return bam_aux_pkg::CODE_U16;  // S
      8'h69:   return bam_aux_pkg::CODE_S32;  // i
      8'h49:   return bam_aux_pkg::CODE_U32;  // I
      8'h66:   return bam_aux_pkg::CODE_F32;  // f
      8'h5A:   return bam_aux_pkg::CODE_Z;    // Z
      default: return bam_aux_pkg::CODE_NONE; // H, B and anything else
    endcase
  endfunction

  // Result word carries the tag gathered so far
  function automatic void queue_result(input bam_aux_pkg::kind_t k, input logic [3:0] code,
                                       input logic [31:0] val, input logic [7:0] ch);
    bam_aux_pkg::result_t r;
    r.kind        = k;
    r.tag_chars   = tag_q;
    r.type_code   = code;
    r.value       = val;
    r.string_char = ch;
    expected_results.push_back(r);
  endfunction

  function automatic void check_field(input string fname, input logic [31:0] expv,
                                      input logic [31:0] actv);
    if (expv !== actv) begin
      $error("%s mismatch: expected %0h, got %0h", fname, expv, actv);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    bam_aux_pkg::result_t exp_word;
    logic [7:0]  b;
    logic        eor;
    logic [3:0]  code;
    logic [1:0]  last_idx;
    if (!rst_n) begin
      phase_q = WAIT_TAG0;
      tag_q   = '0;
      type_q  = '0;
      idx_q   = '0;
      acc_q   = '0;
      expected_results.delete();
    end else begin
      // outgoing word: compare against the oldest prediction
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result word: kind %0h data %0h", out_tuser, out_tdata);
          fail_count++;
        end else begin
          exp_word = expected_results.pop_front();
          check_field("kind", 32'(exp_word.kind), 32'(out_tuser));
          check_field("tag_chars", 32'(exp_word.tag_chars), 32'(out_tdata[15:0]));
          check_field("type_code", 32'(exp_word.type_code), 32'(out_tdata[19:16]));
          check_field("value", exp_word.value, out_tdata[51:20]);
          check_field("string_char", 32'(exp_word.string_char), 32'(out_tdata[59:52]));
          check_field("pad", 32'd0, 32'(out_tdata[63:60]));
        end
      end

      // incoming word: advance the predicted parser
      if (in_tvalid && in_tready) begin
        b   = in_tdata;
        eor = in_tlast;
        unique case (phase_q)
          WAIT_TAG1: begin
            tag_q[15:8] = b;
            if (eor) begin
              phase_q = WAIT_TAG0;
              queue_result(bam_aux_pkg::KIND_ERROR, bam_aux_pkg::CODE_A, 32'd0, 8'd0);
            end else begin
              phase_q = WAIT_TYPE;
            end
          end
          WAIT_TYPE: begin
            code = decode_type(b);
            if (code == bam_aux_pkg::CODE_NONE) begin
              type_q  = '0;
              phase_q = eor ? WAIT_TAG0 : SKIPPING;
              queue_result(bam_aux_pkg::KIND_ERROR, bam_aux_pkg::CODE_A, 32'd0, 8'd0);
            end else begin
              type_q = code;
              idx_q  = '0;
              acc_q  = '0;
              if (eor) begin
                phase_q = WAIT_TAG0;
                queue_result(bam_aux_pkg::KIND_ERROR, type_q, 32'd0, 8'd0);
              end else begin
                phase_q = (code == bam_aux_pkg::CODE_Z) ? IN_STRING : IN_VALUE;
              end
            end
          end
          IN_VALUE: begin
            acc_q    = acc_q | ({24'd0, b} << (8 * idx_q));
            last_idx = (type_q <= bam_aux_pkg::CODE_U8)  ? 2'd0 :
                       (type_q <= bam_aux_pkg::CODE_U16) ? 2'd1 : 2'd3;
            if (idx_q >= last_idx) begin
              phase_q = WAIT_TAG0;
              queue_result(bam_aux_pkg::KIND_SCALAR, type_q, acc_q, 8'd0);
            end else if (eor) begin
              // record cut short inside the value
              phase_q = WAIT_TAG0;
              queue_result(bam_aux_pkg::KIND_ERROR, type_q, 32'd0, 8'd0);
            end else begin
              idx_q = idx_q + 2'd1;
            end
          end
          IN_STRING: begin
            if (b == 8'd0) begin
              phase_q = WAIT_TAG0;
              queue_result(bam_aux_pkg::KIND_END, bam_aux_pkg::CODE_Z, 32'd0, 8'd0);
            end else if (eor) begin
              phase_q = WAIT_TAG0;
              queue_result(bam_aux_pkg::KIND_ERROR, bam_aux_pkg::CODE_Z, 32'd0, 8'd0);
            end else begin
              queue_result(bam_aux_pkg::KIND_CHAR, bam_aux_pkg::CODE_Z, 32'd0, b);
            end
          end
          SKIPPING: begin
            if (eor) begin
              phase_q = WAIT_TAG0;
            end
          end
          default: begin
            tag_q  = {8'd0, b};
            type_q = '0;
            if (eor) begin
              phase_q = WAIT_TAG0;
              queue_result(bam_aux_pkg::KIND_ERROR, bam_aux_pkg::CODE_A, 32'd0, 8'd0);
            end else begin
              phase_q = WAIT_TAG1;
            end
          end
        endcase
      end
    end
    results_pending = expected_results.size();
  end

endmodule

// File: tb/sv/tb_bam_aux_tag_parser.sv
// Testbench top for bam_aux_tag_parser: builds record byte streams, drives
// them with random gaps and stalls, and reports the verdict.
// Depends on bam_aux_pkg, bam_aux_tag_parser and bam_aux_result_checker.
module tb_bam_aux_tag_parser;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 300000;
  localparam int BYTES_PER_PHASE = 310;
  // known type bytes in type-code order: A c C s S i I f Z
  localparam logic [71:0] TYPE_BYTES =
    {8'h5A, 8'h66, 8'h49, 8'h69, 8'h53, 8'h73, 8'h43, 8'h63, 8'h41};

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_mark;
  } in_word_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] data_byte
  logic        in_tlast;   // end_of_record
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;  // [15:0] tag_chars, [19:16] type_code,
                           // [51:20] value, [59:52] string_char, [63:60] zero
  logic [1:0]  out_tuser;  // [1:0] kind

  int fail_count;
  int results_pending;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  in_word_t byte_plan[$];

  always #5 clk = ~clk;

  bam_aux_tag_parser u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  bam_aux_result_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tlast        (in_tlast),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .fail_count      (fail_count),
    .results_pending (results_pending)
  );

  // Receiver stalls at random
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_bam_aux_tag_parser: FAIL");
      $finish;
    end
  end

  task automatic add_byte(input logic [7:0] b, input logic eor);
    in_word_t w;
    w.data_byte = b;
    w.end_mark  = eor;
    byte_plan.push_back(w);
  endtask

  initial begin
    in_word_t   word;
    logic [7:0] field[$];
    int         ph, n, f, i, t, len, pick, cut, vb;
    logic       bad_type;

    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = 8'd0;
    in_tlast   = 1'b0;
    out_tready = 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    for (ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 21 : (ph == 1) ? 87 : 0;
      recv_idle_pct = (ph == 0) ? 87 : (ph == 1) ? 21 : 0;

      if (ph == 0) begin
        // 'S' scalar with extreme tag and value bytes, end mark on last value byte
        add_byte(8'h00, 1'b0); add_byte(8'hFF, 1'b0); add_byte(8'h53, 1'b0);
        add_byte(8'hFF, 1'b0); add_byte(8'hFF, 1'b1);
        // Z string: one char and NUL
        add_byte(8'h58, 1'b0); add_byte(8'h59, 1'b0); add_byte(8'h5A, 1'b0);
        add_byte(8'h80, 1'b0); add_byte(8'h00, 1'b0);
        // hex string type: error, then skip to end mark
        add_byte(8'h61, 1'b0); add_byte(8'h62, 1'b0); add_byte(8'h48, 1'b0);
        add_byte(8'h41, 1'b0); add_byte(8'h00, 1'b1);
        // record ends on first tag byte
        add_byte(8'h7F, 1'b1);
        // record ends on second tag byte
        add_byte(8'h4E, 1'b0); add_byte(8'h4D, 1'b1);
        // record ends on a known type byte
        add_byte(8'h4E, 1'b0); add_byte(8'h4D, 1'b0); add_byte(8'h5A, 1'b1);
        // record ends inside a 32-bit value
        add_byte(8'h4E, 1'b0); add_byte(8'h4D, 1'b0); add_byte(8'h69, 1'b0);
        add_byte(8'h12, 1'b1);
        // record ends inside a string
        add_byte(8'h58, 1'b0); add_byte(8'h5A, 1'b0); add_byte(8'h5A, 1'b0);
        add_byte(8'h41, 1'b1);
      end

      // Random records: mostly well-formed, some cut short, bad types and noise
      while (byte_plan.size() < BYTES_PER_PHASE) begin
        if ($urandom_range(99) < 8) begin
          n = $urandom_range(1, 8);
          for (i = 0; i < n; i++) add_byte(8'($urandom), i == n - 1);
        end else begin
          n = $urandom_range(1, 4);
          for (f = 0; f < n; f++) begin
            field.delete();
            field.push_back(8'($urandom));
            field.push_back(8'($urandom));
            pick     = $urandom_range(99);
            bad_type = 1'b0;
            if (pick < 85) begin
              t = $urandom_range(0, 8);
              field.push_back(TYPE_BYTES[8*t +: 8]);
              if (t == 8) begin
                len = $urandom_range(0, 6);
                repeat (len) field.push_back(8'($urandom_range(1, 255)));
                field.push_back(8'h00);
              end else begin
                len = (t <= 2) ? 1 : (t <= 4) ? 2 : 4;
                repeat (len) begin
                  vb = $urandom_range(9);
                  field.push_back(vb == 0 ? 8'h00 : vb == 1 ? 8'hFF : 8'($urandom));
                end
              end
            end else begin
              // H, B or an arbitrary type byte, then bytes to be skipped
              bad_type = 1'b1;
              if (pick < 92) begin
                field.push_back($urandom_range(1) ? 8'h48 : 8'h42);
              end else begin
                field.push_back(8'($urandom));
              end
              len = $urandom_range(0, 4);
              repeat (len) field.push_back(8'($urandom));
            end
            cut = field.size();
            if (f == n - 1 && !bad_type && $urandom_range(99) < 15) begin
              cut = $urandom_range(1, field.size());
            end
            for (i = 0; i < cut; i++) begin
              add_byte(field[i], (bad_type || f == n - 1) && i == cut - 1);
            end
            if (bad_type) break;
          end
        end
      end

      // Drive the planned words with random sender gaps
      while (byte_plan.size() != 0) begin
        word = byte_plan.pop_front();
        while ($urandom_range(99) < send_idle_pct) begin
          in_tvalid <= 1'b0;
          @(negedge clk);
        end
        in_tvalid <= 1'b1;
        in_tdata  <= word.data_byte;
        in_tlast  <= word.end_mark;
        @(posedge clk);
        while (!in_tready) @(posedge clk);
        @(negedge clk);
      end
    end

    in_tvalid <= 1'b0;
    while (results_pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_count == 0 && results_pending == 0) begin
      $display("tb_bam_aux_tag_parser: PASS");
    end else begin
      $display("tb_bam_aux_tag_parser: FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/bam_aux_pkg.sv
hw/rtl/bam_aux_tag_parser.sv
tb/sv/bam_aux_result_checker.sv
tb/sv/tb_bam_aux_tag_parser.sv
